>>> rtl/hdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_pkg
// Shared types and constants for the hierarchical depth pyramid.
// ----------------------------------------------------------------------------
package hdp_pkg;

  // default configuration
  localparam int HDP_SIDE_LOG2   = 8;
  localparam int HDP_DEPTH_BITS  = 24;
  localparam int HDP_QUEUE_DEPTH = 2;

  // port field widths
  localparam int CMD_W      = 2;
  localparam int COORD_IN_W = 8;
  localparam int DEPTH_IN_W = 24;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAG  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // operation class handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_FRAG  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } hdp_op_e;

  localparam int OP_W = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_F_RD,
    ST_F_CMP,
    ST_UP_AB,
    ST_UP_C,
    ST_UP_W,
    ST_Q_RD,
    ST_Q_CMP,
    ST_DONE
  } hdp_state_e;

endpackage

>>> rtl/hdp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module hdp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re0_i,
  input  logic [AW-1:0]    raddr0_i,
  output logic [WIDTH-1:0] rdata0_o,
  input  logic             re1_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re0_i) begin
      rdata0_q <= mem_q[raddr0_i];
    end
    if (re1_i) begin
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

>>> rtl/hdp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_front
// Input front end: accepts transactions, classifies the command, wraps the
// coordinates to the screen and saturates the depth to the stored format.
// ----------------------------------------------------------------------------
module hdp_front #(
  parameter int SIDE_LOG2  = hdp_pkg::HDP_SIDE_LOG2,
  parameter int DEPTH_BITS = hdp_pkg::HDP_DEPTH_BITS,
  localparam int ITEM_W    = hdp_pkg::OP_W + 4 * SIDE_LOG2 + DEPTH_BITS
) (
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hdp_pkg::CMD_W-1:0]           command_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]      x_low_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]      y_low_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]      x_high_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]      y_high_i,
  input  logic signed [hdp_pkg::DEPTH_IN_W-1:0] depth_i,
  input  logic                                q_full_i,
  input  logic                                init_busy_i,
  output logic                                push_o,
  output logic [ITEM_W-1:0]                   item_o
);

  localparam logic signed [32:0] DMAX = 33'((64'sd1 << (DEPTH_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0] DMIN = -DMAX - 33'sd1;

  hdp_pkg::hdp_op_e        op;
  logic signed [32:0]      depth_ext;
  logic signed [32:0]      depth_sat;
  logic [SIDE_LOG2-1:0]    xl, yl, xh, yh;

  always_comb begin
    unique case (command_i)
      hdp_pkg::CMD_CLEAR: op = hdp_pkg::OP_CLEAR;
      hdp_pkg::CMD_FRAG:  op = hdp_pkg::OP_FRAG;
      hdp_pkg::CMD_QUERY: op = hdp_pkg::OP_QUERY;
      default:            op = hdp_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    depth_ext = 33'(depth_i);
    if (depth_ext > DMAX) begin
      depth_sat = DMAX;
    end else if (depth_ext < DMIN) begin
      depth_sat = DMIN;
    end else begin
      depth_sat = depth_ext;
    end
  end

  // only the low SIDE_LOG2 bits of a coordinate count
  assign xl = SIDE_LOG2'(x_low_i);
  assign yl = SIDE_LOG2'(y_low_i);
  assign xh = SIDE_LOG2'(x_high_i);
  assign yh = SIDE_LOG2'(y_high_i);

  assign in_stall_o = q_full_i | init_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;
  assign item_o     = {op, xl, yl, xh, yh, DEPTH_BITS'(depth_sat)};

endmodule

>>> rtl/hdp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module hdp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hdp_pkg::HDP_QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);

endmodule

>>> rtl/hdp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_back
// Back end: sequencer over the pyramid memory. Runs clear sweeps, fragment
// test and min propagation, and coarse-to-fine box queries.
// ----------------------------------------------------------------------------
module hdp_back #(
  parameter int SIDE_LOG2  = hdp_pkg::HDP_SIDE_LOG2,
  parameter int DEPTH_BITS = hdp_pkg::HDP_DEPTH_BITS,
  localparam int ITEM_W    = hdp_pkg::OP_W + 4 * SIDE_LOG2 + DEPTH_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  logic [ITEM_W-1:0] q_item_i,
  output logic              q_pop_o,
  output logic              init_busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              visible_o
);

  localparam int S       = SIDE_LOG2;
  localparam int DB      = DEPTH_BITS;
  localparam int ENTRIES = ((4 ** (S + 1)) - 1) / 3;
  localparam int AW      = $clog2(ENTRIES);
  localparam int LW      = $clog2(S + 1);
  localparam logic signed [DB-1:0] DEPTH_MIN = {1'b1, {(DB - 1) {1'b0}}};

  // level base is a run of set bits at 2S, 2S-2, ... ; the in-level offset
  // sits entirely below the lowest of them, so an OR forms the address
  function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] lvl,
                                              input logic [S-1:0]  cx,
                                              input logic [S-1:0]  cy);
    logic [AW-1:0] a;
    a = '0;
    for (int k = 0; k <= S; k++) begin
      if (k + int'(lvl) > S) begin
        a[2*k] = 1'b1;
      end
    end
    a = a | (AW'(cy) << (LW'(S) - lvl)) | AW'(cx);
    return a;
  endfunction

  function automatic logic signed [DB-1:0] dmin(input logic signed [DB-1:0] a,
                                                input logic signed [DB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  hdp_pkg::hdp_state_e state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic                init_q, init_d;
  logic                out_valid_q, out_valid_d;

  logic [S-1:0]           x_q, x_d, y_q, y_d, xh_q, xh_d, yh_q, yh_d;
  logic signed [DB-1:0]   d_q, d_d, own_q, own_d, m_q, m_d;
  logic [LW-1:0]          lvl_q, lvl_d;
  logic                   res_q, res_d;
  logic                   visible_q, visible_d;

  // item fields
  hdp_pkg::hdp_op_e       it_op;
  logic [S-1:0]           it_xl, it_yl, it_xh, it_yh;
  logic signed [DB-1:0]   it_d;

  // memory port
  logic                   we, re0, re1;
  logic [AW-1:0]          waddr, raddr0, raddr1;
  logic [DB-1:0]          wdata, rdata0, rdata1;
  logic signed [DB-1:0]   rd0, rd1;

  logic                   out_free;
  logic                   clr_last;
  logic                   frag_win;
  logic                   up_top;
  logic [S-1:0]           ax, ay;
  logic                   box_fits;
  logic                   q_hit;
  logic signed [DB-1:0]   parent;

  assign it_op = hdp_pkg::hdp_op_e'(q_item_i[ITEM_W-1 -: hdp_pkg::OP_W]);
  assign it_xl = q_item_i[DB + 4*S - 1 -: S];
  assign it_yl = q_item_i[DB + 3*S - 1 -: S];
  assign it_xh = q_item_i[DB + 2*S - 1 -: S];
  assign it_yh = q_item_i[DB + S - 1 -: S];
  assign it_d  = q_item_i[DB-1:0];

  assign rd0 = rdata0;
  assign rd1 = rdata1;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign clr_last = (cnt_q == AW'(ENTRIES - 1));
  assign frag_win = (d_q > rd0);
  assign up_top   = (lvl_q == LW'(S - 1));
  assign ax       = x_q >> lvl_q;
  assign ay       = y_q >> lvl_q;
  assign box_fits = (ax == (xh_q >> lvl_q)) && (ay == (yh_q >> lvl_q));
  assign q_hit    = (rd0 >= d_q);
  assign parent   = dmin(m_q, rd0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hdp_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          unique case (it_op)
            hdp_pkg::OP_CLEAR: state_d = hdp_pkg::ST_CLEAR;
            hdp_pkg::OP_FRAG:  state_d = hdp_pkg::ST_F_RD;
            hdp_pkg::OP_QUERY: state_d = hdp_pkg::ST_Q_RD;
            hdp_pkg::OP_NOP:   state_d = hdp_pkg::ST_DONE;
          endcase
        end
      end
      hdp_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = init_q ? hdp_pkg::ST_IDLE : hdp_pkg::ST_DONE;
        end
      end
      hdp_pkg::ST_F_RD:  state_d = hdp_pkg::ST_F_CMP;
      hdp_pkg::ST_F_CMP: state_d = frag_win ? hdp_pkg::ST_UP_AB : hdp_pkg::ST_DONE;
      hdp_pkg::ST_UP_AB: state_d = hdp_pkg::ST_UP_C;
      hdp_pkg::ST_UP_C:  state_d = hdp_pkg::ST_UP_W;
      hdp_pkg::ST_UP_W:  state_d = up_top ? hdp_pkg::ST_DONE : hdp_pkg::ST_UP_AB;
      hdp_pkg::ST_Q_RD:  state_d = box_fits ? hdp_pkg::ST_Q_CMP : hdp_pkg::ST_DONE;
      hdp_pkg::ST_Q_CMP: begin
        if (q_hit || lvl_q == '0) begin
          state_d = hdp_pkg::ST_DONE;
        end else begin
          state_d = hdp_pkg::ST_Q_RD;
        end
      end
      hdp_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = hdp_pkg::ST_IDLE;
        end
      end
      default: state_d = hdp_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d       = cnt_q;
    init_d      = init_q;
    out_valid_d = out_valid_q;
    visible_d   = visible_q;
    x_d         = x_q;
    y_d         = y_q;
    xh_d        = xh_q;
    yh_d        = yh_q;
    d_d         = d_q;
    own_d       = own_q;
    m_d         = m_q;
    lvl_d       = lvl_q;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = cnt_q;
    wdata       = DEPTH_MIN;
    re0         = 1'b0;
    raddr0      = cell_addr(lvl_q, x_q, y_q);
    re1         = 1'b0;
    raddr1      = cell_addr(lvl_q, x_q, y_q ^ S'(1));

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      hdp_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          x_d     = it_xl;
          y_d     = it_yl;
          xh_d    = it_xh;
          yh_d    = it_yh;
          d_d     = it_d;
          cnt_d   = '0;
          res_d   = 1'b0;
          lvl_d   = (it_op == hdp_pkg::OP_QUERY) ? LW'(S) : '0;
        end
      end
      hdp_pkg::ST_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + AW'(1);
        if (clr_last) begin
          init_d = 1'b0;
          res_d  = 1'b1;
        end
      end
      hdp_pkg::ST_F_RD: begin
        re0 = 1'b1;
      end
      hdp_pkg::ST_F_CMP: begin
        if (frag_win) begin
          we    = 1'b1;
          waddr = cell_addr(lvl_q, x_q, y_q);
          wdata = d_q;
          own_d = d_q;
        end else begin
          res_d = 1'b0;
        end
      end
      hdp_pkg::ST_UP_AB: begin
        // two of the three siblings; own value is already held
        re0    = 1'b1;
        raddr0 = cell_addr(lvl_q, x_q ^ S'(1), y_q);
        re1    = 1'b1;
      end
      hdp_pkg::ST_UP_C: begin
        re0    = 1'b1;
        raddr0 = cell_addr(lvl_q, x_q ^ S'(1), y_q ^ S'(1));
        m_d    = dmin(own_q, dmin(rd0, rd1));
      end
      hdp_pkg::ST_UP_W: begin
        we    = 1'b1;
        waddr = cell_addr(lvl_q + LW'(1), x_q >> 1, y_q >> 1);
        wdata = parent;
        own_d = parent;
        x_d   = x_q >> 1;
        y_d   = y_q >> 1;
        lvl_d = lvl_q + LW'(1);
        if (up_top) begin
          res_d = 1'b1;
        end
      end
      hdp_pkg::ST_Q_RD: begin
        // once the box spans two cells, every finer level does too
        if (box_fits) begin
          re0    = 1'b1;
          raddr0 = cell_addr(lvl_q, ax, ay);
        end else begin
          res_d = 1'b1;
        end
      end
      hdp_pkg::ST_Q_CMP: begin
        if (q_hit) begin
          res_d = 1'b0;
        end else if (lvl_q == '0) begin
          res_d = 1'b1;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end
      hdp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          visible_d   = res_q;
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hdp_pkg::ST_CLEAR;
      cnt_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    xh_q      <= xh_d;
    yh_q      <= yh_d;
    d_q       <= d_d;
    own_q     <= own_d;
    m_q       <= m_d;
    lvl_q     <= lvl_d;
    res_q     <= res_d;
    visible_q <= visible_d;
  end

  hdp_ram #(
    .WIDTH (DB),
    .DEPTH (ENTRIES)
  ) u_pyramid (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re0_i    (re0),
    .raddr0_i (raddr0),
    .rdata0_o (rdata0),
    .re1_i    (re1),
    .raddr1_i (raddr1),
    .rdata1_o (rdata1)
  );

  assign init_busy_o = init_q;
  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

endmodule

>>> rtl/hierarchical_depth_pyramid_core.sv
`timescale 1ns / 1ps
// Fragment: read and compare the base cell; if it wins, per level: two sibling reads, min, parent write.
// Query: one read and one compare per level tested, coarsest first.
// Clear: one pyramid entry per cycle, (4^(SIDE_LOG2+1)-1)/3 entries in all (87381 at defaults).
// One transaction in the back end at a time; the memory port (one write, two reads) bounds it.
// After reset a clearing pass over all pyramid entries runs; in_stall_o is high till it ends.
// ----------------------------------------------------------------------------
// hierarchical_depth_pyramid_core
// Hierarchical depth pyramid: front end, transaction queue and memory back end.
// ----------------------------------------------------------------------------
module hierarchical_depth_pyramid_core #(
  parameter int SIDE_LOG2  = hdp_pkg::HDP_SIDE_LOG2,
  parameter int DEPTH_BITS = hdp_pkg::HDP_DEPTH_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [hdp_pkg::CMD_W-1:0]             command_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]        x_low_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]        y_low_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]        x_high_i,
  input  logic [hdp_pkg::COORD_IN_W-1:0]        y_high_i,
  input  logic signed [hdp_pkg::DEPTH_IN_W-1:0] depth_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  visible_o
);

  localparam int ITEM_W = hdp_pkg::OP_W + 4 * SIDE_LOG2 + DEPTH_BITS;

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  logic              init_busy;
  logic [ITEM_W-1:0] item_in;
  logic [ITEM_W-1:0] item_out;

  hdp_front #(
    .SIDE_LOG2  (SIDE_LOG2),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .x_low_i     (x_low_i),
    .y_low_i     (y_low_i),
    .x_high_i    (x_high_i),
    .y_high_i    (y_high_i),
    .depth_i     (depth_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .item_o      (item_in)
  );

  hdp_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (hdp_pkg::HDP_QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (item_in),
    .pop_i   (pop),
    .rdata_o (item_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hdp_back #(
    .SIDE_LOG2  (SIDE_LOG2),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (item_out),
    .q_pop_o     (pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for hierarchical_depth_pyramid_core. A local copy of the depth
// pyramid predicts the visible flag of every accepted transaction; results
// are checked in order against that prediction while both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb;
  import hdp_pkg::*;

  localparam int SIDE_LOG2       = HDP_SIDE_LOG2;
  localparam int LEVELS          = SIDE_LOG2 + 1;
  localparam int ENTRIES         = ((1 << (2 * LEVELS)) - 1) / 3;
  localparam int WATCHDOG_CYCLES = 400000;  // a clear alone sweeps all ENTRIES cells
  localparam int END_CYCLES      = 200;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef logic signed [DEPTH_IN_W-1:0] depth_t;
  typedef logic [COORD_IN_W-1:0] coord_t;

  localparam depth_t DEPTH_FAR  = {1'b1, {(DEPTH_IN_W - 1){1'b0}}};
  localparam depth_t DEPTH_NEAR = ~DEPTH_FAR;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CMD_W-1:0] command_i;
  coord_t           x_low_i;
  coord_t           y_low_i;
  coord_t           x_high_i;
  coord_t           y_high_i;
  depth_t           depth_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             visible_o;

  // local copy of the pyramid: level 0 first, each level row-major
  depth_t pyramid [ENTRIES];
  logic   visible_expected [$];
  logic   visible_due;
  int     items_sent;
  int     results_seen;
  int     mismatches;
  bit     sender_gaps_on;

  hierarchical_depth_pyramid_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .x_low_i     (x_low_i),
    .y_low_i     (y_low_i),
    .x_high_i    (x_high_i),
    .y_high_i    (y_high_i),
    .depth_i     (depth_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------

  function automatic int cell_addr(int lvl, int cx, int cy);
    int base;
    base = 0;
    for (int k = 0; k < lvl; k++) base += 1 << (2 * (SIDE_LOG2 - k));
    return base + (cy << (SIDE_LOG2 - lvl)) + cx;
  endfunction

  function automatic depth_t min_depth(depth_t a, depth_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic void clear_pyramid();
    foreach (pyramid[i]) pyramid[i] = DEPTH_FAR;
  endfunction

  // DEPTH_BITS equals the port width, so the input needs no saturation
  function automatic bit write_fragment(int x, int y, depth_t d);
    int     cx;
    int     cy;
    depth_t m;
    if (!(d > pyramid[cell_addr(0, x, y)])) return 1'b0;
    pyramid[cell_addr(0, x, y)] = d;
    for (int lvl = 1; lvl < LEVELS; lvl++) begin
      cx = x & ~1;
      cy = y & ~1;
      m = pyramid[cell_addr(lvl - 1, cx, cy)];
      m = min_depth(m, pyramid[cell_addr(lvl - 1, cx + 1, cy)]);
      m = min_depth(m, pyramid[cell_addr(lvl - 1, cx, cy + 1)]);
      m = min_depth(m, pyramid[cell_addr(lvl - 1, cx + 1, cy + 1)]);
      x = x >> 1;
      y = y >> 1;
      pyramid[cell_addr(lvl, x, y)] = m;
    end
    return 1'b1;
  endfunction

  // coarsest level first; any single covering cell at or nearer than d rejects
  function automatic bit box_rejected(int x0, int y0, int x1, int y1, depth_t d);
    for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
      if ((x0 >> lvl) == (x1 >> lvl) && (y0 >> lvl) == (y1 >> lvl) &&
          pyramid[cell_addr(lvl, x0 >> lvl, y0 >> lvl)] >= d)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic predict_visible(logic [CMD_W-1:0] cmd, coord_t xl, coord_t yl,
                                           coord_t xh, coord_t yh, depth_t d);
    case (cmd)
      CMD_CLEAR: begin
        clear_pyramid();
        return 1'b1;
      end
      CMD_FRAG:  return write_fragment(int'(xl), int'(yl), d);
      CMD_QUERY: return !box_rejected(int'(xl), int'(yl), int'(xh), int'(yh), d);
      default:   return 1'b0;
    endcase
  endfunction

  // ---------------- driving ----------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_item(logic [CMD_W-1:0] cmd, int xl, int yl, int xh, int yh, depth_t d);
    if (sender_gaps_on) idle_sender(pick_gap());
    @(negedge clk_i);
    in_valid_i = 1'b1;
    command_i  = cmd;
    x_low_i    = coord_t'(xl);
    y_low_i    = coord_t'(yl);
    x_high_i   = coord_t'(xh);
    y_high_i   = coord_t'(yh);
    depth_i    = d;
    do @(posedge clk_i); while (in_stall_o);
    visible_expected.insert(visible_expected.size(),
                            predict_visible(command_i, x_low_i, y_low_i,
                                            x_high_i, y_high_i, depth_i));
    items_sent++;
  endtask

  task automatic send_fragment(int x, int y, depth_t d);
    send_item(CMD_FRAG, x, y, $urandom_range(0, 255), $urandom_range(0, 255), d);
  endtask

  task automatic send_query(int x0, int y0, int x1, int y1, depth_t d);
    send_item(CMD_QUERY, x0, y0, x1, y1, d);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (visible_expected.size() != 0) @(posedge clk_i);
  endtask

  // ---------------- checking ----------------

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("tb mismatch @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (visible_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        visible_due = visible_expected.pop_front();
        if (visible_o !== visible_due)
          report_mismatch($sformatf("result %0d visible: expected %b got %b",
                                    results_seen, visible_due, visible_o));
      end
    end
  end

  initial begin : receiver_stall
    int sel;
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        out_stall_i = 1'b0;
        hold = $urandom_range(20, 150);
      end else if (sel < 3) begin
        out_stall_i = 1'b1;
        hold = $urandom_range(10, 40);
      end else begin
        out_stall_i = 1'($urandom_range(0, 1));
        hold = $urandom_range(0, 3);
      end
      repeat (hold) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------- tests ----------------

  // pyramid comes out of reset all farthest
  task automatic test_after_reset();
    send_query(0, 0, 255, 255, DEPTH_FAR);
    send_query(0, 0, 255, 255, depth_t'(DEPTH_FAR + 1));
    send_fragment(0, 0, DEPTH_FAR);
    send_query(0, 0, 0, 0, DEPTH_FAR);
  endtask

  task automatic test_fragment_rules();
    send_fragment(0, 0, DEPTH_NEAR);
    send_fragment(0, 0, DEPTH_NEAR);      // equal depth is not written
    send_fragment(255, 255, 0);
    send_fragment(255, 255, -1);          // farther
    send_fragment(255, 255, 5);
    send_fragment(254, 254, 7);
    send_fragment(255, 254, 9);
    send_fragment(254, 255, 5);
  endtask

  // level-1 cell at (127,127) now holds minimum 5
  task automatic test_query_rules();
    send_query(254, 254, 255, 255, 5);    // equal depth rejects
    send_query(254, 254, 255, 255, 6);
    send_query(255, 255, 254, 254, 5);    // inverted box
    send_query(253, 254, 255, 255, 5);    // spans two level-1 cells
    send_query(0, 0, 0, 0, DEPTH_NEAR);
  endtask

  task automatic test_unused_command();
    send_item(CMD_SPARE, 255, 255, 255, 255, DEPTH_NEAR);
    send_query(254, 254, 255, 255, 5);
  endtask

  task automatic test_clear();
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
    send_query(254, 254, 255, 255, depth_t'(DEPTH_FAR + 1));
  endtask

  // fill an aligned square with nearby depths, then probe it with boxes
  task automatic run_tile();
    int size;
    int bx;
    int by;
    int base;
    int x0;
    int y0;
    int sel;
    size = 1 << $urandom_range(1, 3);
    bx = $urandom_range(0, 255) & ~(size - 1);
    by = $urandom_range(0, 255) & ~(size - 1);
    sel = $urandom_range(0, 7);
    if (sel == 0) base = int'(DEPTH_FAR) + 8;
    else if (sel == 1) base = int'(DEPTH_NEAR) - 24;
    else base = int'($urandom_range(16, 24'hFFFFC0)) - 24'h800000;
    for (int j = 0; j < size; j++)
      for (int i = 0; i < size; i++)
        if ($urandom_range(0, 15) != 0)
          send_fragment(bx + i, by + j, depth_t'(base + int'($urandom_range(0, 15))));
    repeat ($urandom_range(3, 8)) begin
      x0 = bx + $urandom_range(0, size - 1);
      y0 = by + $urandom_range(0, size - 1);
      if ($urandom_range(0, 5) == 0)
        send_query(x0, y0, x0 + $urandom_range(0, 2 * size), y0 + $urandom_range(0, size),
                   depth_t'(base + int'($urandom_range(0, 24)) - 4));
      else
        send_query(x0, y0, bx + $urandom_range(0, size - 1), by + $urandom_range(0, size - 1),
                   depth_t'(base + int'($urandom_range(0, 24)) - 4));
      if ($urandom_range(0, 2) == 0)
        send_fragment(bx + $urandom_range(0, size - 1), by + $urandom_range(0, size - 1),
                      depth_t'(base + int'($urandom_range(0, 20))));
    end
  endtask

  task automatic run_noise();
    int sel;
    repeat ($urandom_range(8, 20)) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        send_fragment($urandom_range(0, 255), $urandom_range(0, 255), depth_t'($urandom));
      else if (sel < 8)
        send_query($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), depth_t'($urandom));
      else
        send_item(CMD_SPARE, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255), depth_t'($urandom));
    end
  endtask

  task automatic test_random_traffic(int goal);
    while (items_sent < goal) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) run_tile();
      else run_noise();
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    sender_gaps_on = 1'b1;
  endtask

  // sender holds off until the pipe is empty, then clears mid-run
  task automatic test_midrun_clear();
    drain_results();
    send_item(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255), depth_t'($urandom));
    send_query(0, 0, 255, 255, DEPTH_FAR);
  endtask

  initial begin : main_seq
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_CLEAR;
    x_low_i        = '0;
    y_low_i        = '0;
    x_high_i       = '0;
    y_high_i       = '0;
    depth_i        = '0;
    items_sent     = 0;
    results_seen   = 0;
    mismatches     = 0;
    sender_gaps_on = 1'b1;
    clear_pyramid();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_fragment_rules();
    test_query_rules();
    test_unused_command();
    test_clear();
    test_random_traffic(400);
    test_midrun_clear();
    test_random_traffic(730);
    test_midrun_clear();
    test_random_traffic(1035);

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (visible_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", visible_expected.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
